// ===== hw/rtl/uds_memory_transfer_control_defines.svh =====
// assertion macros for the transfer control block
`ifndef UDS_MEMORY_TRANSFER_CONTROL_DEFINES_SVH
`define UDS_MEMORY_TRANSFER_CONTROL_DEFINES_SVH

`ifndef ASSERT_OFF
// condition implies consequence in the same cycle
`define UMTC_ASSERT_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// condition implies consequence in the next cycle
`define UMTC_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define UMTC_ASSERT_SAME(name, ante, cons, msg)
`define UMTC_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/umtc_pkg.sv =====
`default_nettype none

package umtc_pkg;

   // request kinds
   typedef enum logic [1:0] {
      REQ_START_UPLOAD   = 2'd0,
      REQ_START_DOWNLOAD = 2'd1,
      REQ_TRANSFER_DATA  = 2'd2,
      REQ_TRANSFER_EXIT  = 2'd3
   } req_kind_type;

   // resolved memory regions
   typedef enum logic [1:0] {
      REGION_NONE = 2'd0,
      REGION_CFG  = 2'd1,
      REGION_LOG  = 2'd2,
      REGION_UID  = 2'd3
   } region_type;

   // config flash region, upload only
   localparam logic [31:0] CFG_LO    = 32'hC200_0080;
   localparam logic [31:0] CFG_HI    = 32'hC200_0FFF;
   localparam logic [31:0] CFG_PHYS  = 32'h0800_0080;
   // log flash region, both directions
   localparam logic [31:0] LOG_LO    = 32'hC300_1000;
   localparam logic [31:0] LOG_HI    = 32'hC3FF_FFFF;
   localparam logic [31:0] LOG_PHYS  = 32'h0801_0000;
   // unique id region, upload only
   localparam logic [31:0] UID_LO    = 32'hC500_0000;
   localparam logic [31:0] UID_HI    = 32'hC500_007F;
   localparam logic [31:0] UID_PHYS  = 32'h1FFF_7590;

   // logical to physical offsets, modulo 2^32
   localparam logic [31:0] CFG_DELTA = CFG_PHYS - CFG_LO;
   localparam logic [31:0] LOG_DELTA = LOG_PHYS - LOG_LO;
   localparam logic [31:0] UID_DELTA = UID_PHYS - UID_LO;

   // exclusive end of each logical region
   localparam logic [32:0] CFG_LIMIT = {1'b0, CFG_HI} + 33'd1;
   localparam logic [32:0] LOG_LIMIT = {1'b0, LOG_HI} + 33'd1;
   localparam logic [32:0] UID_LIMIT = {1'b0, UID_HI} + 33'd1;

   // physical flash window and id size
   localparam logic [31:0] FLASH_START = 32'h0800_0000;
   localparam logic [32:0] FLASH_BYTES = 33'd262144;
   localparam logic [32:0] FLASH_LIMIT = {1'b0, FLASH_START} + FLASH_BYTES;
   localparam logic [32:0] ID_BYTES    = 33'd12;

   // sequence counter and register defaults
   localparam logic [7:0]  SEQ_FIRST         = 8'd1;
   localparam logic [15:0] MAX_BLOCK_DEFAULT = 16'd256;

   // one request
   typedef struct packed {
      req_kind_type kind;
      logic [31:0]  uds_address;
      logic [31:0]  transfer_length;
      logic [7:0]   seq_counter;
      logic [15:0]  block_request;
   } req_item_type;

   // one result
   typedef struct packed {
      logic        accepted;
      region_type  region_id;
      logic [31:0] phys_address;
      logic [15:0] block_bytes;
      logic [15:0] granted_block_max;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== hw/rtl/umtc_in_stage.sv =====
`default_nettype none

module umtc_in_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire umtc_pkg::req_item_type req_item,
   input  wire logic                  take,
   output logic                       valid,
   output umtc_pkg::req_item_type     item
);

   logic                   valid_ff;
   logic                   valid_in;
   umtc_pkg::req_item_type item_ff;

   // room when empty or when the held request moves on
   assign req_ready = !valid_ff || take;

   always_comb begin
      if (req_ready) begin
         valid_in = req_valid;
      end else begin
         valid_in = valid_ff;
      end
   end

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // request payload, loaded on each input transfer
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign valid = valid_ff;
   assign item  = item_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/umtc_engine.sv =====
`default_nettype none

module umtc_engine (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   fire,
   input  wire umtc_pkg::req_item_type item,
   input  wire logic [15:0]            max_block_length,
   output umtc_pkg::rsp_item_type      rsp
);

   // transfer state
   logic                   active_ff, active_in;
   logic                   is_upload_ff, is_upload_in;
   umtc_pkg::region_type   region_ff, region_in;
   logic [31:0]            cur_address_ff, cur_address_in;
   logic [31:0]            bytes_left_ff, bytes_left_in;
   logic [7:0]             expected_seq_ff, expected_seq_in;

   // start request terms
   logic                   start_upload;
   logic [32:0]            start_end;
   logic                   hit_cfg, hit_log, hit_uid;
   umtc_pkg::region_type   start_region;
   logic [31:0]            start_phys;

   // transfer data terms
   logic [31:0]            xfer_lo;
   logic [31:0]            xfer_delta;
   logic [31:0]            xfer_offset;
   logic [31:0]            xfer_phys;
   logic [15:0]            up_cap;
   logic [15:0]            up_len;
   logic                   dn_too_long;
   logic [15:0]            xfer_len;
   logic [32:0]            id_end;
   logic [32:0]            flash_end;
   logic                   range_good;
   logic                   xfer_pre;
   logic                   xfer_good;
   logic [7:0]             seq_inc;
   logic [7:0]             seq_next;

   // region resolve for start requests
   assign start_upload = (item.kind == umtc_pkg::REQ_START_UPLOAD);
   assign start_end    = {1'b0, item.uds_address} + {1'b0, item.transfer_length};
   assign hit_cfg = (item.uds_address >= umtc_pkg::CFG_LO) &&
                    (item.uds_address <= umtc_pkg::CFG_HI);
   assign hit_log = (item.uds_address >= umtc_pkg::LOG_LO) &&
                    (item.uds_address <= umtc_pkg::LOG_HI);
   assign hit_uid = (item.uds_address >= umtc_pkg::UID_LO) &&
                    (item.uds_address <= umtc_pkg::UID_HI);

   always_comb begin
      start_region = umtc_pkg::REGION_NONE;
      start_phys   = 32'd0;
      priority if (hit_cfg) begin
         if (start_end <= umtc_pkg::CFG_LIMIT && start_upload) begin
            start_region = umtc_pkg::REGION_CFG;
         end
         start_phys = item.uds_address + umtc_pkg::CFG_DELTA;
      end else if (hit_log) begin
         if (start_end <= umtc_pkg::LOG_LIMIT) begin
            start_region = umtc_pkg::REGION_LOG;
         end
         start_phys = item.uds_address + umtc_pkg::LOG_DELTA;
      end else if (hit_uid) begin
         if (start_end <= umtc_pkg::UID_LIMIT && start_upload) begin
            start_region = umtc_pkg::REGION_UID;
         end
         start_phys = item.uds_address + umtc_pkg::UID_DELTA;
      end
   end

   // region base and offset of the active transfer
   always_comb begin
      unique case (region_ff)
         umtc_pkg::REGION_CFG: begin
            xfer_lo    = umtc_pkg::CFG_LO;
            xfer_delta = umtc_pkg::CFG_DELTA;
         end
         umtc_pkg::REGION_LOG: begin
            xfer_lo    = umtc_pkg::LOG_LO;
            xfer_delta = umtc_pkg::LOG_DELTA;
         end
         umtc_pkg::REGION_UID: begin
            xfer_lo    = umtc_pkg::UID_LO;
            xfer_delta = umtc_pkg::UID_DELTA;
         end
         default: begin
            xfer_lo    = 32'd0;
            xfer_delta = 32'd0;
         end
      endcase
   end

   assign xfer_offset = cur_address_ff - xfer_lo;
   assign xfer_phys   = cur_address_ff + xfer_delta;

   // block sizing: upload takes the smallest limit, download is checked
   assign up_cap = (bytes_left_ff < {16'd0, max_block_length}) ?
                   bytes_left_ff[15:0] : max_block_length;
   assign up_len = (item.block_request < up_cap) ? item.block_request : up_cap;
   assign dn_too_long = ({16'd0, item.block_request} > bytes_left_ff);
   assign xfer_len = is_upload_ff ? up_len : item.block_request;

   // physical range check of the block
   assign id_end    = {1'b0, xfer_offset} + {17'd0, xfer_len};
   assign flash_end = {1'b0, xfer_phys} + {17'd0, xfer_len};

   always_comb begin
      if (xfer_len == 16'd0) begin
         range_good = 1'b0;
      end else if (region_ff == umtc_pkg::REGION_UID) begin
         range_good = (id_end <= umtc_pkg::ID_BYTES);
      end else begin
         range_good = (xfer_phys >= umtc_pkg::FLASH_START) &&
                      (flash_end <= umtc_pkg::FLASH_LIMIT);
      end
   end

   assign xfer_pre  = active_ff && (region_ff != umtc_pkg::REGION_NONE) &&
                      (item.seq_counter == expected_seq_ff);
   assign xfer_good = xfer_pre && !(!is_upload_ff && dn_too_long) && range_good;

   // sequence counter skips zero on wrap
   assign seq_inc  = expected_seq_ff + 8'd1;
   assign seq_next = (seq_inc == 8'd0) ? umtc_pkg::SEQ_FIRST : seq_inc;

   // result and next state per request kind
   always_comb begin
      rsp             = '0;
      active_in       = active_ff;
      is_upload_in    = is_upload_ff;
      region_in       = region_ff;
      cur_address_in  = cur_address_ff;
      bytes_left_in   = bytes_left_ff;
      expected_seq_in = expected_seq_ff;
      unique case (item.kind)
         umtc_pkg::REQ_START_UPLOAD, umtc_pkg::REQ_START_DOWNLOAD: begin
            if (start_region != umtc_pkg::REGION_NONE) begin
               rsp.accepted          = 1'b1;
               rsp.region_id         = start_region;
               rsp.phys_address      = start_phys;
               rsp.granted_block_max = max_block_length;
               active_in       = 1'b1;
               is_upload_in    = start_upload;
               region_in       = start_region;
               cur_address_in  = item.uds_address;
               bytes_left_in   = item.transfer_length;
               expected_seq_in = umtc_pkg::SEQ_FIRST;
            end
         end
         umtc_pkg::REQ_TRANSFER_DATA: begin
            if (xfer_good) begin
               rsp.accepted     = 1'b1;
               rsp.region_id    = region_ff;
               rsp.phys_address = xfer_phys;
               rsp.block_bytes  = xfer_len;
               cur_address_in  = cur_address_ff + {16'd0, xfer_len};
               bytes_left_in   = bytes_left_ff - {16'd0, xfer_len};
               expected_seq_in = seq_next;
            end
         end
         umtc_pkg::REQ_TRANSFER_EXIT: begin
            if (active_ff) begin
               active_in = 1'b0;
               if (bytes_left_ff == 32'd0) begin
                  rsp.accepted  = 1'b1;
                  rsp.region_id = region_ff;
               end
            end
         end
         default: begin
            rsp = '0;
         end
      endcase
   end

   // state registers, updated as each request moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff       <= 1'b0;
         is_upload_ff    <= 1'b0;
         region_ff       <= umtc_pkg::REGION_NONE;
         cur_address_ff  <= 32'd0;
         bytes_left_ff   <= 32'd0;
         expected_seq_ff <= 8'd0;
      end else if (fire) begin
         active_ff       <= active_in;
         is_upload_ff    <= is_upload_in;
         region_ff       <= region_in;
         cur_address_ff  <= cur_address_in;
         bytes_left_ff   <= bytes_left_in;
         expected_seq_ff <= expected_seq_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/umtc_out_stage.sv =====
`default_nettype none

module umtc_out_stage (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   load,
   input  wire umtc_pkg::rsp_item_type rsp_item,
   output logic                        room,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output umtc_pkg::rsp_item_type      item
);

   logic                   valid_ff;
   logic                   valid_in;
   umtc_pkg::rsp_item_type item_ff;

   // a new result fits when empty or when the held one leaves
   assign room = !valid_ff || rsp_ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= rsp_item;
      end
   end

   assign rsp_valid = valid_ff;
   assign item      = item_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/uds_memory_transfer_control.sv =====
// channel   direction  transfer when           payload
// req_      in         req_tvalid & tready     tuser kind, tdata address/length/seq/block
// rsp_      out        rsp_tvalid & tready     tuser status/region, tdata phys/len/max
// csr_      in         csr_valid & csr_ready   max_block_length
//
// one request per cycle while rsp_tready stays high; a result follows its request transfer
// (input register, then the state update and result register in one stage)
// the transfer state feeds back inside that stage; each request sees the prior update
// synchronous reset clears both stage flags and the transfer state and sets
// max_block_length to 256
// with rsp_tready low the result holds, one more request is held, then req_tready drops

`default_nettype none

`include "uds_memory_transfer_control_defines.svh"

module uds_memory_transfer_control (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_tuser,   // [1:0] req_type
   input  wire logic [87:0] req_tdata,   // [31:0] uds_address, [63:32] transfer_length,
                                         // [71:64] seq_counter, [87:72] block_request
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [2:0]       rsp_tuser,   // [0] accepted, [2:1] region_id
   output logic [63:0]      rsp_tdata,   // [31:0] phys_address, [47:32] block_bytes,
                                         // [63:48] granted_block_max
   // register write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data     // max_block_length
);

   umtc_pkg::req_item_type req_item;
   umtc_pkg::req_item_type stage_item;
   umtc_pkg::rsp_item_type eval_rsp;
   umtc_pkg::rsp_item_type out_item;
   logic                   stage_valid;
   logic                   out_room;
   logic                   fire;
   logic [15:0]            max_block_ff;

   // unpack request
   assign req_item.kind            = umtc_pkg::req_kind_type'(req_tuser);
   assign req_item.uds_address     = req_tdata[31:0];
   assign req_item.transfer_length = req_tdata[63:32];
   assign req_item.seq_counter     = req_tdata[71:64];
   assign req_item.block_request   = req_tdata[87:72];

   // block length register, always writable
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_block_ff <= umtc_pkg::MAX_BLOCK_DEFAULT;
      end else if (csr_valid && csr_ready) begin
         max_block_ff <= csr_data;
      end
   end

   umtc_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_item  (req_item),
      .take      (fire),
      .valid     (stage_valid),
      .item      (stage_item)
   );

   // request moves from input register to result register
   assign fire = stage_valid && out_room;

   umtc_engine u_engine (
      .clock            (clock),
      .reset            (reset),
      .fire             (fire),
      .item             (stage_item),
      .max_block_length (max_block_ff),
      .rsp              (eval_rsp)
   );

   umtc_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .rsp_item  (eval_rsp),
      .room      (out_room),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .item      (out_item)
   );

   // pack result
   assign rsp_tuser = {out_item.region_id, out_item.accepted};
   assign rsp_tdata = {out_item.granted_block_max, out_item.block_bytes,
                       out_item.phys_address};

   // checks
   `UMTC_ASSERT_SAME(a_reject_zero, rsp_tvalid && !rsp_tuser[0], rsp_tdata == 64'd0 && rsp_tuser == 3'd0, "rejected result carries data")
   `UMTC_ASSERT_SAME(a_accept_region, rsp_tvalid && rsp_tuser[0], rsp_tuser[2:1] != 2'd0, "accepted result without region")
   `UMTC_ASSERT_SAME(a_stall_no_fire, rsp_tvalid && !rsp_tready, !fire, "result overwritten while stalled")
   `UMTC_ASSERT_SAME(a_full_no_req, stage_valid && !fire, !req_tready, "input register overrun")
   `UMTC_ASSERT_NEXT(a_fire_valid, fire, rsp_tvalid, "evaluated request lost")

endmodule

`default_nettype wire
